[rtl/rgb_to_hsv_converter_defines.svh]
// shared assertion macros for the rgb to hsv converter
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter: check failed");

// condition that must hold in the cycle after a reset cycle
`define RHC_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("rgb_to_hsv_converter: reset check failed");

`endif

[rtl/rhc_pkg.sv]
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CHAN_W           = 8;
    localparam int HUE_W            = 15;
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 32;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // side information that travels with each pixel through the dividers
    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic [CHAN_W-1:0]   brightness;
    } pix_side_t;

    // hue units per 60 degree sector
    function automatic int hue_sector_units(input int frac);
        return 60 << frac;
    endfunction

    // quotient bits of both dividers; saturation needs 8
    function automatic int div_steps(input int frac);
        int qb;
        qb = $clog2((60 << frac) + 1);
        return (qb > CHAN_W) ? qb : CHAN_W;
    endfunction

endpackage

[rtl/rgb_to_hsv_converter.sv]
// from the s transfer to m_tvalid a pixel is registered in rhc_front, in each rhc_div_step and in rhc_back
// throughput: one pixel per cycle while m_tready is high; the two dividers retire one quotient bit per stage
// each stage holds its own valid bit, so empty stages keep taking pixels while m_tready is low
// reset: synchronous active-low aresetn clears all valid bits; data registers are not reset
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // hue[14:0], saturation[22:15],
                                             // brightness[30:23], zero[31]
);

    localparam int NSTEP  = div_steps(HUE_FRAC_BITS);
    localparam int HUE_LIM = 360 << HUE_FRAC_BITS;

    logic               valid [0:NSTEP];
    logic               ready [0:NSTEP];
    pix_side_t          side  [0:NSTEP];
    logic [CHAN_W-1:0]  sat_rem [0:NSTEP];
    logic [NSTEP-1:0]   sat_nq  [0:NSTEP];
    logic [CHAN_W-1:0]  sat_den [0:NSTEP];
    logic [CHAN_W-1:0]  hue_rem [0:NSTEP];
    logic [NSTEP-1:0]   hue_nq  [0:NSTEP];
    logic [CHAN_W-1:0]  hue_den [0:NSTEP];

    rhc_front #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .side      (side[0]),
        .sat_rem   (sat_rem[0]),
        .sat_nq    (sat_nq[0]),
        .sat_den   (sat_den[0]),
        .hue_rem   (hue_rem[0]),
        .hue_nq    (hue_nq[0]),
        .hue_den   (hue_den[0])
    );

    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        rhc_div_step #(
            .HUE_FRAC_BITS(HUE_FRAC_BITS)
        ) u_step (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_valid    (valid[k]),
            .in_ready    (ready[k]),
            .in_side     (side[k]),
            .in_sat_rem  (sat_rem[k]),
            .in_sat_nq   (sat_nq[k]),
            .in_sat_den  (sat_den[k]),
            .in_hue_rem  (hue_rem[k]),
            .in_hue_nq   (hue_nq[k]),
            .in_hue_den  (hue_den[k]),
            .out_valid   (valid[k+1]),
            .out_ready   (ready[k+1]),
            .out_side    (side[k+1]),
            .out_sat_rem (sat_rem[k+1]),
            .out_sat_nq  (sat_nq[k+1]),
            .out_sat_den (sat_den[k+1]),
            .out_hue_rem (hue_rem[k+1]),
            .out_hue_nq  (hue_nq[k+1]),
            .out_hue_den (hue_den[k+1])
        );
    end

    rhc_back #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (valid[NSTEP]),
        .in_ready   (ready[NSTEP]),
        .in_side    (side[NSTEP]),
        .in_sat_nq  (sat_nq[NSTEP]),
        .in_hue_rem (hue_rem[NSTEP]),
        .in_hue_nq  (hue_nq[NSTEP]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // a stalled input means every stage, the output one included, holds a pixel
    `RHC_ASSERT_IMP(a_stall_needs_output, !s_tready, m_tvalid)
    // nonzero saturation only comes with a nonzero largest channel
    `RHC_ASSERT_IMP(a_sat_needs_value, m_tvalid && (m_tdata[22:15] != 8'd0), m_tdata[30:23] != 8'd0)
    // hue stays below a full turn whenever it fits the field unmasked
    `RHC_ASSERT_IMP(a_hue_range, m_tvalid, (HUE_LIM > 32767) || (m_tdata[14:0] < HUE_LIM))
    `RHC_ASSERT_RST(a_reset_clears, !m_tvalid)

endmodule

[rtl/rhc_front.sv]
`timescale 1ns / 1ps

module rhc_front import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [CHAN_W-1:0]                 red,
    input  logic [CHAN_W-1:0]                 green,
    input  logic [CHAN_W-1:0]                 blue,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pix_side_t                         side,
    output logic [CHAN_W-1:0]                 sat_rem,
    output logic [div_steps(HUE_FRAC_BITS)-1:0] sat_nq,
    output logic [CHAN_W-1:0]                 sat_den,
    output logic [CHAN_W-1:0]                 hue_rem,
    output logic [div_steps(HUE_FRAC_BITS)-1:0] hue_nq,
    output logic [CHAN_W-1:0]                 hue_den
);

    localparam int SECTOR_U = hue_sector_units(HUE_FRAC_BITS);
    localparam int NSTEP    = div_steps(HUE_FRAC_BITS);
    localparam int NW       = NSTEP + CHAN_W;

    logic [CHAN_W-1:0] mx, mn, delta, mag;
    logic [15:0]       sat_prod;
    logic [NW-1:0]     sat_num, hue_num;
    pix_side_t         side_next;

    logic                valid_reg;
    pix_side_t           side_reg;
    logic [CHAN_W-1:0]   sat_rem_reg, sat_den_reg, hue_rem_reg, hue_den_reg;
    logic [NSTEP-1:0]    sat_nq_reg, hue_nq_reg;

    always_comb begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        delta = mx - mn;

        side_next.brightness = mx;
        if (red >= mx) begin
            side_next.sector = SECTOR_RED;
            side_next.neg    = (green < blue);
            mag = (green >= blue) ? green - blue : blue - green;
        end else if (green >= mx) begin
            side_next.sector = SECTOR_GREEN;
            side_next.neg    = (blue < red);
            mag = (blue >= red) ? blue - red : red - blue;
        end else begin
            side_next.sector = SECTOR_BLUE;
            side_next.neg    = (red < green);
            mag = (red >= green) ? red - green : green - red;
        end

        // 255 * delta as a shift and subtract
        sat_prod = {delta, 8'h00} - {8'h00, delta};
        sat_num  = NW'(sat_prod);
        hue_num  = NW'(SECTOR_U) * {{(NW-CHAN_W){1'b0}}, mag};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // quotient fits in NSTEP bits, so the upper numerator bits start as remainder
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg    <= side_next;
            sat_rem_reg <= sat_num[NW-1:NSTEP];
            sat_nq_reg  <= sat_num[NSTEP-1:0];
            sat_den_reg <= (mx == '0) ? CHAN_W'(1) : mx;
            hue_rem_reg <= hue_num[NW-1:NSTEP];
            hue_nq_reg  <= hue_num[NSTEP-1:0];
            hue_den_reg <= (delta == '0) ? CHAN_W'(1) : delta;
        end
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign sat_rem   = sat_rem_reg;
    assign sat_nq    = sat_nq_reg;
    assign sat_den   = sat_den_reg;
    assign hue_rem   = hue_rem_reg;
    assign hue_nq    = hue_nq_reg;
    assign hue_den   = hue_den_reg;

endmodule

[rtl/rhc_div_step.sv]
`timescale 1ns / 1ps

module rhc_div_step import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pix_side_t                         in_side,
    input  logic [CHAN_W-1:0]                 in_sat_rem,
    input  logic [div_steps(HUE_FRAC_BITS)-1:0] in_sat_nq,
    input  logic [CHAN_W-1:0]                 in_sat_den,
    input  logic [CHAN_W-1:0]                 in_hue_rem,
    input  logic [div_steps(HUE_FRAC_BITS)-1:0] in_hue_nq,
    input  logic [CHAN_W-1:0]                 in_hue_den,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pix_side_t                         out_side,
    output logic [CHAN_W-1:0]                 out_sat_rem,
    output logic [div_steps(HUE_FRAC_BITS)-1:0] out_sat_nq,
    output logic [CHAN_W-1:0]                 out_sat_den,
    output logic [CHAN_W-1:0]                 out_hue_rem,
    output logic [div_steps(HUE_FRAC_BITS)-1:0] out_hue_nq,
    output logic [CHAN_W-1:0]                 out_hue_den
);

    localparam int NSTEP = div_steps(HUE_FRAC_BITS);

    logic [CHAN_W:0]     sat_trial, hue_trial;
    logic                sat_bit, hue_bit;
    logic [CHAN_W-1:0]   sat_rem_next, hue_rem_next;
    logic [NSTEP-1:0]    sat_nq_next, hue_nq_next;

    logic                valid_reg;
    pix_side_t           side_reg;
    logic [CHAN_W-1:0]   sat_rem_reg, sat_den_reg, hue_rem_reg, hue_den_reg;
    logic [NSTEP-1:0]    sat_nq_reg, hue_nq_reg;

    // one restoring step for each divider; the quotient bit shifts in at the bottom
    always_comb begin
        sat_trial    = {in_sat_rem, in_sat_nq[NSTEP-1]};
        sat_bit      = (sat_trial >= {1'b0, in_sat_den});
        sat_rem_next = sat_bit ? CHAN_W'(sat_trial - {1'b0, in_sat_den})
                               : sat_trial[CHAN_W-1:0];
        sat_nq_next  = {in_sat_nq[NSTEP-2:0], sat_bit};

        hue_trial    = {in_hue_rem, in_hue_nq[NSTEP-1]};
        hue_bit      = (hue_trial >= {1'b0, in_hue_den});
        hue_rem_next = hue_bit ? CHAN_W'(hue_trial - {1'b0, in_hue_den})
                               : hue_trial[CHAN_W-1:0];
        hue_nq_next  = {in_hue_nq[NSTEP-2:0], hue_bit};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg    <= in_side;
            sat_rem_reg <= sat_rem_next;
            sat_nq_reg  <= sat_nq_next;
            sat_den_reg <= in_sat_den;
            hue_rem_reg <= hue_rem_next;
            hue_nq_reg  <= hue_nq_next;
            hue_den_reg <= in_hue_den;
        end
    end

    assign out_valid   = valid_reg;
    assign out_side    = side_reg;
    assign out_sat_rem = sat_rem_reg;
    assign out_sat_nq  = sat_nq_reg;
    assign out_sat_den = sat_den_reg;
    assign out_hue_rem = hue_rem_reg;
    assign out_hue_nq  = hue_nq_reg;
    assign out_hue_den = hue_den_reg;

endmodule

[rtl/rhc_back.sv]
`timescale 1ns / 1ps

module rhc_back import rhc_pkg::*; #(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pix_side_t                         in_side,
    input  logic [div_steps(HUE_FRAC_BITS)-1:0] in_sat_nq,
    input  logic [CHAN_W-1:0]                 in_hue_rem,
    input  logic [div_steps(HUE_FRAC_BITS)-1:0] in_hue_nq,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata
);

    localparam int NSTEP    = div_steps(HUE_FRAC_BITS);
    localparam int SECTOR_U = hue_sector_units(HUE_FRAC_BITS);
    localparam int FULL_U   = 360 << HUE_FRAC_BITS;
    localparam int FULL_B   = $clog2(FULL_U + 1);
    localparam int HCW      = ((FULL_B > HUE_W) ? FULL_B : HUE_W) + 2;

    logic signed [HCW-1:0] base, quo, off, sum, hue_full;
    logic [HUE_W-1:0]      hue_next;
    logic [M_TDATA_W-1:0]  tdata_next;

    logic                  valid_reg;
    logic [M_TDATA_W-1:0]  tdata_reg;

    always_comb begin
        case (in_side.sector)
            SECTOR_RED:   base = '0;
            SECTOR_GREEN: base = HCW'(2 * SECTOR_U);
            SECTOR_BLUE:  base = HCW'(4 * SECTOR_U);
            default:      base = '0;
        endcase

        quo = signed'({{(HCW-NSTEP){1'b0}}, in_hue_nq});
        // floor of a negative quotient: round the magnitude up when a remainder is left
        if (in_side.neg) begin
            off = -(quo + HCW'(in_hue_rem != '0));
        end else begin
            off = quo;
        end
        sum      = base + off;
        hue_full = (sum < 0) ? sum + HCW'(FULL_U) : sum;
        hue_next = hue_full[HUE_W-1:0];

        tdata_next = {1'b0, in_side.brightness, in_sat_nq[CHAN_W-1:0], hue_next};
    end

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;

endmodule
